// ===== hw/rtl/vid_pkg.sv =====
// Vector instruction decoder package: opcodes, command and result types,
// queue depths and fixed-point constants. No dependencies.
`timescale 1ns / 1ps

package vid_pkg;

  localparam int FRAC_BITS_DEF = 17;

  localparam int WORD_W   = 16;
  localparam int COORD_W  = 48;
  localparam int MAG_W    = 11;
  localparam int SHIFT_W  = 5;
  localparam int INT_W    = 5;
  localparam int ROT_W    = 16;
  localparam int ROT_FRAC = 14;
  localparam int PROD_W   = 27;
  localparam int SUM_W    = 28;
  localparam int WIDE_W   = 62;

  localparam int CMD_DEPTH = 4;
  localparam int OUT_DEPTH = 4;
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_ROT_COS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_SIN = 1'd1;

  localparam logic signed [ROT_W-1:0] ROT_COS_RST = 16'sd16384;
  localparam logic signed [ROT_W-1:0] ROT_SIN_RST = 16'sd0;

  localparam logic [WIDE_W-1:0] ROUND_HALF = WIDE_W'(1) << (ROT_FRAC - 1);

  localparam logic [3:0] OP_LONG_MAX = 4'd9;
  localparam logic [3:0] OP_LOAD     = 4'd10;
  localparam logic [3:0] OP_RETURN   = 4'd13;
  localparam logic [3:0] OP_SHORT    = 4'd15;

  localparam int LONG_BIAS  = 9;
  localparam int SHORT_BIAS = 7;

  localparam logic [INT_W-1:0] BRIGHTEN_ADD = 5'd2;

  typedef enum logic [1:0] {
    KIND_VECTOR  = 2'd0,
    KIND_RETURN  = 2'd1,
    KIND_INVALID = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    CMD_VECTOR,
    CMD_RETURN,
    CMD_INVALID,
    CMD_LOAD
  } cmd_e;

  typedef enum logic [1:0] {
    HELD_NONE = 2'd0,
    HELD_LONG = 2'd1,
    HELD_LOAD = 2'd2
  } held_e;

  typedef struct packed {
    cmd_e                     kind;
    logic signed [MAG_W-1:0]  dx;
    logic signed [MAG_W-1:0]  dy;
    logic [SHIFT_W-1:0]       shamt;
    logic [INT_W-1:0]         intensity;
  } cmd_t;

  typedef struct packed {
    kind_e                     kind;
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] move_x;
    logic signed [COORD_W-1:0] move_y;
    logic [INT_W-1:0]          intensity;
  } res_t;

  function automatic logic signed [MAG_W-1:0] sign_mag(logic neg, logic [MAG_W-2:0] mag);
    logic signed [MAG_W-1:0] v;
    v = $signed({1'b0, mag});
    return neg ? -v : v;
  endfunction

endpackage

// ===== hw/rtl/vid_fifo.sv =====
// Small register queue with simultaneous push and pop, used between the
// decoder parts. Depends on nothing but its type parameter.
`timescale 1ns / 1ps

module vid_fifo #(
  parameter type entry_t = logic,
  parameter int  DEPTH   = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  entry_t                     data_i,
  input  logic                       pop_i,
  output entry_t                     data_o,
  output logic                       full_o,
  output logic                       empty_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t             mem_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]   count_q;
  logic               wr_en, rd_en;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign count_o = count_q;
  assign data_o  = mem_q[rd_ptr_q];
  assign wr_en   = push_i && !full_o;
  assign rd_en   = pop_i && !empty_o;

  function automatic logic [PTR_W-1:0] next_ptr(logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (wr_en) wr_ptr_q <= next_ptr(wr_ptr_q);
      if (rd_en) rd_ptr_q <= next_ptr(rd_ptr_q);
      if (wr_en && !rd_en) count_q <= count_q + CNT_W'(1);
      else if (rd_en && !wr_en) count_q <= count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_ptr_q] <= data_i;
  end

endmodule

// ===== hw/rtl/vid_front.sv =====
// Front end: takes program words, pairs two-word instructions, tracks the
// global scale and emits decoded commands. Depends on vid_pkg.
`timescale 1ns / 1ps

module vid_front
  import vid_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [WORD_W-1:0] word_i,
  input  logic              brighten_i,
  output logic              cmd_push_o,
  output cmd_t              cmd_o
);

  logic [WORD_W-1:0] held_word_q, held_word_d;
  held_e             held_kind_q, held_kind_d;
  logic [3:0]        scale_q, scale_d;
  logic              cmd_gen;

  always_comb begin
    logic [3:0] op;
    logic [3:0] held_op;
    int         sh_long;
    int         sh_short;
    op       = word_i[15:12];
    held_op  = held_word_q[15:12];
    sh_long  = FRAC_BITS - LONG_BIAS + int'(held_op) + int'($signed(scale_q));
    sh_short = FRAC_BITS - SHORT_BIAS + int'({word_i[3], word_i[11]})
               + int'($signed(scale_q));

    held_word_d   = held_word_q;
    held_kind_d   = held_kind_q;
    scale_d       = scale_q;
    cmd_gen       = 1'b0;
    cmd_o.kind      = CMD_INVALID;
    cmd_o.dx        = '0;
    cmd_o.dy        = '0;
    cmd_o.shamt     = '0;
    cmd_o.intensity = '0;

    unique case (held_kind_q)
      HELD_LONG: begin
        cmd_gen         = 1'b1;
        cmd_o.kind      = CMD_VECTOR;
        cmd_o.dx        = sign_mag(word_i[10], word_i[9:0]);
        cmd_o.dy        = sign_mag(held_word_q[10], held_word_q[9:0]);
        cmd_o.shamt     = SHIFT_W'(sh_long);
        cmd_o.intensity = {1'b0, op};
        held_kind_d     = HELD_NONE;
      end
      HELD_LOAD: begin
        cmd_gen     = 1'b1;
        cmd_o.kind  = CMD_LOAD;
        cmd_o.dx    = sign_mag(word_i[10], word_i[9:0]);
        cmd_o.dy    = sign_mag(held_word_q[10], held_word_q[9:0]);
        scale_d     = op;
        held_kind_d = HELD_NONE;
      end
      HELD_NONE: begin
        unique case (op) inside
          [4'd0:OP_LONG_MAX]: begin
            held_word_d = word_i;
            held_kind_d = HELD_LONG;
          end
          OP_LOAD: begin
            held_word_d = word_i;
            held_kind_d = HELD_LOAD;
          end
          OP_RETURN: begin
            cmd_gen    = 1'b1;
            cmd_o.kind = CMD_RETURN;
          end
          OP_SHORT: begin
            cmd_gen         = 1'b1;
            cmd_o.kind      = CMD_VECTOR;
            cmd_o.dx        = sign_mag(word_i[2], {word_i[1:0], 8'd0});
            cmd_o.dy        = sign_mag(word_i[10], {word_i[9:8], 8'd0});
            cmd_o.shamt     = SHIFT_W'(sh_short);
            cmd_o.intensity = {1'b0, word_i[7:4]} + (brighten_i ? BRIGHTEN_ADD : '0);
          end
          default: begin
            cmd_gen    = 1'b1;
            cmd_o.kind = CMD_INVALID;
          end
        endcase
      end
      default: begin
        held_kind_d = HELD_NONE;
      end
    endcase
  end

  assign cmd_push_o = accept_i && cmd_gen;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_word_q <= '0;
      held_kind_q <= HELD_NONE;
      scale_q     <= '0;
    end else if (accept_i) begin
      held_word_q <= held_word_d;
      held_kind_q <= held_kind_d;
      scale_q     <= scale_d;
    end
  end

endmodule

// ===== hw/rtl/vid_back.sv =====
// Back end: rotation multiply stage, then scaling, rounding and beam
// accumulation into results. Holds the rotation registers. Depends on vid_pkg.
`timescale 1ns / 1ps

module vid_back
  import vid_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ROT_W-1:0]     cfg_data_i,
  input  cmd_t                 cmd_i,
  input  logic                 cmd_empty_i,
  output logic                 cmd_pop_o,
  input  logic [OUT_CNT_W-1:0] out_count_i,
  output logic                 res_push_o,
  output res_t                 res_o
);

  logic signed [ROT_W-1:0]   rot_cos_q, rot_sin_q;

  logic                      a_valid_q;
  cmd_e                      a_kind_q;
  logic signed [SUM_W-1:0]   a_rx_q, a_ry_q;
  logic signed [MAG_W-1:0]   a_dx_q, a_dy_q;
  logic [SHIFT_W-1:0]        a_shamt_q;
  logic [INT_W-1:0]          a_int_q;

  logic signed [COORD_W-1:0] beam_x_q, beam_x_d, beam_y_q, beam_y_d;

  logic signed [PROD_W-1:0]  p_xc, p_ys, p_xs, p_yc;
  logic signed [SUM_W-1:0]   rx, ry;
  logic                      a_res;
  logic [OUT_CNT_W:0]        used;
  logic [WIDE_W-1:0]         wide_x, wide_y;
  logic [COORD_W-1:0]        move_x, move_y;

  // Config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_cos_q <= ROT_COS_RST;
      rot_sin_q <= ROT_SIN_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_ROT_COS: rot_cos_q <= $signed(cfg_data_i);
        REG_ROT_SIN: rot_sin_q <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  // Issue only when the result queue has room for everything in flight
  assign a_res     = a_valid_q && (a_kind_q != CMD_LOAD);
  assign used      = {1'b0, out_count_i} + (OUT_CNT_W+1)'(a_res);
  assign cmd_pop_o = !cmd_empty_i && (used < (OUT_CNT_W+1)'(OUT_DEPTH));

  // Stage A: rotation products
  assign p_xc = cmd_i.dx * rot_cos_q;
  assign p_ys = cmd_i.dy * rot_sin_q;
  assign p_xs = cmd_i.dx * rot_sin_q;
  assign p_yc = cmd_i.dy * rot_cos_q;
  assign rx   = SUM_W'(p_xc) - SUM_W'(p_ys);
  assign ry   = SUM_W'(p_xs) + SUM_W'(p_yc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= cmd_pop_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      a_kind_q  <= cmd_i.kind;
      a_rx_q    <= rx;
      a_ry_q    <= ry;
      a_dx_q    <= cmd_i.dx;
      a_dy_q    <= cmd_i.dy;
      a_shamt_q <= cmd_i.shamt;
      a_int_q   <= cmd_i.intensity;
    end
  end

  // Stage B: scale, round half up, accumulate
  assign wide_x = (WIDE_W'(a_rx_q) << a_shamt_q) + ROUND_HALF;
  assign wide_y = (WIDE_W'(a_ry_q) << a_shamt_q) + ROUND_HALF;
  assign move_x = wide_x[ROT_FRAC +: COORD_W];
  assign move_y = wide_y[ROT_FRAC +: COORD_W];

  always_comb begin
    beam_x_d          = beam_x_q;
    beam_y_d          = beam_y_q;
    res_o.kind        = KIND_VECTOR;
    res_o.start_x     = beam_x_q;
    res_o.start_y     = beam_y_q;
    res_o.move_x      = '0;
    res_o.move_y      = '0;
    res_o.intensity   = '0;
    case (a_kind_q)
      CMD_VECTOR: begin
        res_o.move_x    = $signed(move_x);
        res_o.move_y    = $signed(move_y);
        res_o.intensity = a_int_q;
        beam_x_d        = beam_x_q + $signed(move_x);
        beam_y_d        = beam_y_q + $signed(move_y);
      end
      CMD_RETURN:  res_o.kind = KIND_RETURN;
      CMD_INVALID: res_o.kind = KIND_INVALID;
      CMD_LOAD: begin
        beam_x_d = COORD_W'(a_dx_q) <<< FRAC_BITS;
        beam_y_d = COORD_W'(a_dy_q) <<< FRAC_BITS;
      end
      default: ;
    endcase
  end

  assign res_push_o = a_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beam_x_q <= '0;
      beam_y_q <= '0;
    end else if (a_valid_q) begin
      beam_x_q <= beam_x_d;
      beam_y_q <= beam_y_d;
    end
  end

endmodule

// ===== hw/rtl/vector_instruction_decoder.sv =====
// Vector instruction decoder top level: front end, command queue, back end
// and result queue. Depends on vid_pkg, vid_fifo, vid_front, vid_back.
//
//   channel   handshake                  payload
//   input     push / full                word_i, brighten_i
//   result    empty / pop                kind_o, start_x_o, start_y_o, move_x_o,
//                                        move_y_o, intensity_o
//   config    cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// One program word per cycle while full is low. A result reaches the ports once
// the completing word has passed the command queue, the multiply stage, then
// rounding and beam update. A four-entry command queue decouples the front from
// the back, a four-entry result queue absorbs pop stalls, and full rises when
// the command queue fills. Reset restores rotation 1.0 and zero beam and scale.
`timescale 1ns / 1ps

module vector_instruction_decoder
  import vid_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push,
  output logic                      full,
  input  logic [WORD_W-1:0]         word_i,
  input  logic                      brighten_i,
  output logic                      empty,
  input  logic                      pop,
  output logic [1:0]                kind_o,
  output logic signed [COORD_W-1:0] start_x_o,
  output logic signed [COORD_W-1:0] start_y_o,
  output logic signed [COORD_W-1:0] move_x_o,
  output logic signed [COORD_W-1:0] move_y_o,
  output logic [INT_W-1:0]          intensity_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [ROT_W-1:0]          cfg_data_i
);

  logic                          accept;
  logic                          cmd_push, cmd_pop, cmd_empty;
  cmd_t                          cmd_in, cmd_out;
  logic [$clog2(CMD_DEPTH+1)-1:0] cmd_count;
  logic                          res_push, res_full;
  res_t                          res_in, res_out;
  logic [OUT_CNT_W-1:0]          res_count;

  assign accept      = push && !full;
  assign cfg_ready_o = 1'b1;

  vid_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .word_i     (word_i),
    .brighten_i (brighten_i),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  vid_fifo #(
    .entry_t (cmd_t),
    .DEPTH   (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .pop_i   (cmd_pop),
    .data_o  (cmd_out),
    .full_o  (full),
    .empty_o (cmd_empty),
    .count_o (cmd_count)
  );

  vid_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd_out),
    .cmd_empty_i (cmd_empty || (cmd_count == '0)),
    .cmd_pop_o   (cmd_pop),
    .out_count_i (res_count),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  vid_fifo #(
    .entry_t (res_t),
    .DEPTH   (OUT_DEPTH)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .pop_i   (pop),
    .data_o  (res_out),
    .full_o  (res_full),
    .empty_o (empty),
    .count_o (res_count)
  );

  assign kind_o      = res_out.kind;
  assign start_x_o   = res_out.start_x;
  assign start_y_o   = res_out.start_y;
  assign move_x_o    = res_out.move_x;
  assign move_y_o    = res_out.move_y;
  assign intensity_o = res_full ? res_out.intensity : res_out.intensity;

endmodule

// ===== verif/vid_checker.sv =====
// Scoreboard for the vector instruction decoder: watches the program-word,
// config and result transfers, predicts each result and compares it.
// Depends on vid_pkg.
`timescale 1ns / 1ps

module vid_checker
  import vid_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  logic                      full_i,
  input  logic [WORD_W-1:0]         word_i,
  input  logic                      brighten_i,
  input  logic                      cfg_valid_i,
  input  logic                      cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [ROT_W-1:0]          cfg_data_i,
  input  logic                      empty_i,
  input  logic                      pop_i,
  input  logic [1:0]                kind_i,
  input  logic [COORD_W-1:0]        start_x_i,
  input  logic [COORD_W-1:0]        start_y_i,
  input  logic [COORD_W-1:0]        move_x_i,
  input  logic [COORD_W-1:0]        move_y_i,
  input  logic [INT_W-1:0]          intensity_i,
  output int                        fail_count_o,
  output int                        pending_o,
  output int                        checked_o,
  output int                        ends_o
);

  logic signed [ROT_W-1:0] rot_cos;
  logic signed [ROT_W-1:0] rot_sin;
  logic [COORD_W-1:0]      beam_x;
  logic [COORD_W-1:0]      beam_y;
  logic [3:0]              scale_code;
  logic [WORD_W-1:0]       held_word;
  held_e                   held_kind;
  res_t                    beam_results_q[$];
  int                      fail_count;
  int                      checked;
  int                      ends;

  function automatic int scale_exp();
    return (scale_code < 4'd8) ? int'(scale_code) : int'(scale_code) - 16;
  endfunction

  // magnitude * 2^ex in fixed point
  function automatic longint fixed_delta(input int unsigned mag, input int ex,
                                         input logic neg);
    int     sh;
    longint m;
    sh = FRAC_BITS_DEF + ex;
    m = longint'(mag);
    if (sh >= 0) begin
      m = m << ((sh > 40) ? 40 : sh);
    end else begin
      m = (-sh > 40) ? 64'sd0 : (m >> -sh);
    end
    return neg ? -m : m;
  endfunction

  task automatic record_vector(input longint dx, input longint dy,
                               input logic [INT_W-1:0] bright);
    longint c;
    longint s;
    longint mx;
    longint my;
    res_t   r;
    c = rot_cos;
    s = rot_sin;
    mx = (dx * c - dy * s + (longint'(1) << (ROT_FRAC - 1))) >>> ROT_FRAC;
    my = (dx * s + dy * c + (longint'(1) << (ROT_FRAC - 1))) >>> ROT_FRAC;
    r.kind      = KIND_VECTOR;
    r.start_x   = beam_x;
    r.start_y   = beam_y;
    r.move_x    = mx[COORD_W-1:0];
    r.move_y    = my[COORD_W-1:0];
    r.intensity = bright;
    beam_results_q.push_back(r);
    beam_x = beam_x + mx[COORD_W-1:0];
    beam_y = beam_y + my[COORD_W-1:0];
  endtask

  task automatic record_end(input kind_e k);
    res_t r;
    r.kind      = k;
    r.start_x   = beam_x;
    r.start_y   = beam_y;
    r.move_x    = '0;
    r.move_y    = '0;
    r.intensity = '0;
    beam_results_q.push_back(r);
  endtask

  task automatic decode_word(input logic [WORD_W-1:0] w, input logic b);
    int     ex;
    longint dx;
    longint dy;
    case (held_kind)
      HELD_LONG: begin
        ex = int'(held_word[15:12]) - LONG_BIAS + scale_exp();
        dy = fixed_delta(held_word[9:0], ex, held_word[10]);
        dx = fixed_delta(w[9:0], ex, w[10]);
        held_kind = HELD_NONE;
        record_vector(dx, dy, INT_W'(w[15:12]));
      end
      HELD_LOAD: begin
        dy = held_word[10] ? -longint'(held_word[9:0]) : longint'(held_word[9:0]);
        dx = w[10] ? -longint'(w[9:0]) : longint'(w[9:0]);
        dy = dy <<< FRAC_BITS_DEF;
        dx = dx <<< FRAC_BITS_DEF;
        beam_y = dy[COORD_W-1:0];
        beam_x = dx[COORD_W-1:0];
        scale_code = w[15:12];
        held_kind = HELD_NONE;
      end
      default: begin
        if (w[15:12] <= OP_LONG_MAX) begin
          held_word = w;
          held_kind = HELD_LONG;
        end else if (w[15:12] == OP_LOAD) begin
          held_word = w;
          held_kind = HELD_LOAD;
        end else if (w[15:12] == OP_RETURN) begin
          record_end(KIND_RETURN);
        end else if (w[15:12] == OP_SHORT) begin
          ex = int'({w[3], w[11]}) - SHORT_BIAS + scale_exp();
          dx = fixed_delta({w[1:0], 8'h00}, ex, w[2]);
          dy = fixed_delta({w[9:8], 8'h00}, ex, w[10]);
          record_vector(dx, dy, INT_W'(w[7:4]) + (b ? BRIGHTEN_ADD : INT_W'(0)));
        end else begin
          record_end(KIND_INVALID);
        end
      end
    endcase
  endtask

  task automatic check_result();
    res_t e;
    if (beam_results_q.size() == 0) begin
      fail_count++;
      if (fail_count <= 10) begin
        $display("[%0t] unexpected result transfer: kind %0d start %h,%h", $realtime,
                 kind_i, start_x_i, start_y_i);
      end
    end else begin
      e = beam_results_q.pop_front();
      checked++;
      if (e.kind != KIND_VECTOR) ends++;
      if (kind_i !== e.kind || start_x_i !== e.start_x || start_y_i !== e.start_y ||
          move_x_i !== e.move_x || move_y_i !== e.move_y ||
          intensity_i !== e.intensity) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("[%0t] mismatch: exp kind %0d start %h,%h move %h,%h int %0d", $realtime,
                   e.kind, e.start_x, e.start_y, e.move_x, e.move_y, e.intensity);
          $display("            got kind %0d start %h,%h move %h,%h int %0d",
                   kind_i, start_x_i, start_y_i, move_x_i, move_y_i, intensity_i);
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_cos    = ROT_COS_RST;
      rot_sin    = ROT_SIN_RST;
      beam_x     = '0;
      beam_y     = '0;
      scale_code = '0;
      held_word  = '0;
      held_kind  = HELD_NONE;
      beam_results_q.delete();
      fail_count = 0;
      checked    = 0;
      ends       = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == REG_ROT_COS) begin
          rot_cos = cfg_data_i;
        end else if (cfg_index_i == REG_ROT_SIN) begin
          rot_sin = cfg_data_i;
        end
      end
      if (pop_i && !empty_i) check_result();
      if (push_i && !full_i) decode_word(word_i, brighten_i);
    end
    fail_count_o <= fail_count;
    pending_o    <= beam_results_q.size();
    checked_o    <= checked;
    ends_o       <= ends;
  end

endmodule

// ===== verif/tb_vector_instruction_decoder.sv =====
// Testbench top for the vector instruction decoder: clock, reset, program-word
// and rotation stimulus, result pop stalls and the verdict.
// Depends on vid_pkg, vector_instruction_decoder and vid_checker.
`timescale 1ns / 1ps

module tb_vector_instruction_decoder;
  import vid_pkg::*;

  localparam int PHASES          = 6;
  localparam int WORDS_PER_PHASE = 67;
  localparam int SETTLE          = 10;
  localparam int CYCLE_LIMIT     = 200000;

  localparam logic [3:0] OP_INVALID_LO  = 4'd11;
  localparam logic [3:0] OP_INVALID_MID = 4'd12;
  localparam logic [3:0] OP_INVALID_HI  = 4'd14;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 push;
  logic                 full;
  logic [WORD_W-1:0]    word;
  logic                 brighten;
  logic                 empty;
  logic                 pop;
  logic [1:0]           kind;
  logic [COORD_W-1:0]   start_x;
  logic [COORD_W-1:0]   start_y;
  logic [COORD_W-1:0]   move_x;
  logic [COORD_W-1:0]   move_y;
  logic [INT_W-1:0]     intensity;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [ROT_W-1:0]     cfg_data;
  logic                 quiet;
  int                   fail_count;
  int                   pending;
  int                   checked;
  int                   ends;
  int                   n_words;
  int                   cycles = 0;

  vector_instruction_decoder u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .word_i      (word),
    .brighten_i  (brighten),
    .empty       (empty),
    .pop         (pop),
    .kind_o      (kind),
    .start_x_o   (start_x),
    .start_y_o   (start_y),
    .move_x_o    (move_x),
    .move_y_o    (move_y),
    .intensity_o (intensity),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  vid_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_i       (full),
    .word_i       (word),
    .brighten_i   (brighten),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .empty_i      (empty),
    .pop_i        (pop),
    .kind_i       (kind),
    .start_x_i    (start_x),
    .start_y_i    (start_y),
    .move_x_i     (move_x),
    .move_y_i     (move_y),
    .intensity_i  (intensity),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked),
    .ends_o       (ends)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("** vector_instruction_decoder: FAILED **");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      pop <= quiet || ($urandom_range(99) >= 29);
    end
  end

  task automatic send_word(input logic [WORD_W-1:0] w, input logic b);
    while (!quiet && $urandom_range(99) < 29) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push     <= 1'b1;
    word     <= w;
    brighten <= b;
    do @(posedge clk_i); while (full);
    n_words++;
  endtask

  task automatic send_random_instruction();
    int unsigned pick;
    logic        b;
    pick = $urandom_range(99);
    b = 1'($urandom);
    if (pick < 30) begin
      send_word({OP_SHORT, 12'($urandom)}, b);
    end else if (pick < 60) begin
      send_word({4'($urandom_range(OP_LONG_MAX)), 12'($urandom)}, b);
      send_word(16'($urandom), 1'($urandom));
    end else if (pick < 70) begin
      send_word({OP_LOAD, 12'($urandom)}, b);
      send_word(16'($urandom), 1'($urandom));
    end else if (pick < 78) begin
      send_word({OP_RETURN, 12'($urandom)}, b);
    end else if (pick < 88) begin
      case ($urandom_range(2))
        0:       send_word({OP_INVALID_LO, 12'($urandom)}, b);
        1:       send_word({OP_INVALID_MID, 12'($urandom)}, b);
        default: send_word({OP_INVALID_HI, 12'($urandom)}, b);
      endcase
    end else begin
      send_word(16'($urandom), b);
    end
  endtask

  // two returns leave nothing held, whether or not a first word was pending
  task automatic drain();
    send_word({OP_RETURN, 12'h000}, 1'b0);
    send_word({OP_RETURN, 12'hFFF}, 1'b1);
    push <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_rotation(input logic [ROT_W-1:0] cos_v, input logic [ROT_W-1:0] sin_v);
    cfg_valid <= 1'b1;
    cfg_index <= REG_ROT_COS;
    cfg_data  <= cos_v;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_index <= REG_ROT_SIN;
    cfg_data  <= sin_v;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int cos_v;
    int sin_v;
    rst_ni    = 1'b0;
    push      = 1'b0;
    word      = '0;
    brighten  = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    quiet     = 1'b0;
    n_words   = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed words at reset rotation
    send_word({OP_SHORT, 12'h000}, 1'b0);
    send_word({OP_SHORT, 12'hFFF}, 1'b1);
    send_word({OP_SHORT, 12'h5A5}, 1'b0);
    send_word({4'd0, 12'h000}, 1'b0);
    send_word(16'h0000, 1'b1);
    send_word({OP_LONG_MAX, 12'h7FF}, 1'b1);
    send_word(16'hF7FF, 1'b1);
    send_word({OP_LOAD, 12'h7FF}, 1'b0);
    send_word({4'd7, 12'h3FF}, 1'b0);
    send_word({OP_LONG_MAX, 12'h3FF}, 1'b0);
    send_word({4'd15, 12'h7FF}, 1'b0);
    send_word({OP_SHORT, 12'hFFF}, 1'b0);
    send_word({OP_LOAD, 12'h000}, 1'b0);
    send_word({4'd8, 12'h000}, 1'b0);
    send_word({4'd0, 12'h001}, 1'b0);
    send_word({4'd0, 12'h401}, 1'b0);
    send_word({OP_SHORT, 12'h807}, 1'b1);
    send_word({OP_RETURN, 12'hFFF}, 1'b0);
    send_word({OP_INVALID_LO, 12'h000}, 1'b0);
    send_word({OP_INVALID_MID, 12'hABC}, 1'b1);
    send_word({OP_INVALID_HI, 12'hFFF}, 1'b0);
    send_word({OP_LOAD, 12'h000}, 1'b0);
    send_word(16'h0000, 1'b0);
    send_word({4'd3, 12'h234}, 1'b1);
    send_word({OP_RETURN, 12'h555}, 1'b0);
    send_word({OP_LOAD, 12'h400}, 1'b0);
    send_word({OP_INVALID_HI, 12'h000}, 1'b0);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin cos_v = 0;      sin_v = 16384;  end
        1: begin cos_v = -16384; sin_v = 0;      end
        2: begin cos_v = 0;      sin_v = -16384; end
        3: begin cos_v = 16384;  sin_v = -16384; end
        default: begin
          cos_v = int'($urandom_range(32768)) - 16384;
          sin_v = int'($urandom_range(32768)) - 16384;
        end
      endcase
      set_rotation(ROT_W'(cos_v), ROT_W'(sin_v));
      quiet <= (p == 2);
      for (int i = 0; i < WORDS_PER_PHASE; i++) send_random_instruction();
      drain();
      quiet <= 1'b0;
    end

    $display("%0d program words over %0d rotation settings; %0d results checked, %0d ends",
             n_words, PHASES + 1, checked, ends);
    if (fail_count == 0) begin
      $display("** vector_instruction_decoder: PASSED **");
    end else begin
      $display("%0d mismatching result transfers", fail_count);
      $display("** vector_instruction_decoder: FAILED **");
    end
    $finish;
  end

endmodule
